### rtl/f2i_pkg.sv
package f2i_pkg;

  localparam logic [10:0] BiasD      = 11'd1023;
  localparam logic [10:0] BiasS      = 11'd127;
  localparam logic [10:0] FracBitsD  = 11'd52;
  localparam logic [10:0] FracBitsS  = 11'd23;

  // decoded operand, format independent
  typedef struct packed {
    logic        neg;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [10:0] exp;
    logic [10:0] bias;
    logic [10:0] frac_bits;
    logic [52:0] mant;
  } op_t;

endpackage

### rtl/float_to_int_round_half_away.sv
// float to signed integer conversion, round to nearest with halves away from zero
//
// s_axis: one item per handshake; tdata bits 63:0 operand_bits (binary32 in 31:0),
//   bit 64 is_single (1 = binary32), bits 71:65 zero
// m_axis: one item per input item; tdata bits 63:0 rounded_value (sign-extended
//   result of RESULT_WIDTH bits), bit 64 invalid, bits 71:65 zero
// stages: one input register and one result register with the decode, shift and
//   saturate logic between them; an accepted item is captured in the input
//   register, and its result is then captured in the result register
// throughput: one item per cycle without receiver stall, single pass datapath
// the shift by exponent is a left shift for large exponents and a right shift
//   otherwise; rounding adds half an ulp of the integer position then drops the fraction
// reset clears both valid flags; payload registers are not reset
// receiver stall: the pipeline holds as a whole, s_axis_tready follows the
//   stages so an item enters whenever the input register is free or draining
// NaN gives 0, infinities and out of range saturate; all three raise invalid
module float_to_int_round_half_away #(
  parameter int unsigned RESULT_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [63:0] operand_bits, [64] is_single
  input  logic        m_axis_tready_i,
  output logic        m_axis_tvalid_o,
  output logic [71:0] m_axis_tdata_o    // [63:0] rounded_value, [64] invalid
);

  localparam int unsigned Rw = (RESULT_WIDTH > 64) ? 64 :
                               ((RESULT_WIDTH < 2) ? 2 : RESULT_WIDTH);
  localparam logic [63:0] NegLimit = 64'd1 << (Rw - 1);
  localparam logic [63:0] PosLimit = NegLimit - 64'd1;

  logic        in_vld_q, out_vld_q;
  logic [63:0] op_q;
  logic        single_q;
  logic [63:0] res_q, res_d;
  logic        inv_q, inv_d;
  logic        adv_out, adv_in;

  // pipeline control
  assign adv_out = !out_vld_q || m_axis_tready_i;
  assign adv_in  = !in_vld_q || adv_out;
  assign s_axis_tready_o = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in)  in_vld_q  <= s_axis_tvalid_i;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid_i) begin
      op_q     <= s_axis_tdata_i[63:0];
      single_q <= s_axis_tdata_i[64];
    end
    if (adv_out && in_vld_q) begin
      res_q <= res_d;
      inv_q <= inv_d;
    end
  end

  // decode
  f2i_pkg::op_t op;
  always_comb begin
    if (single_q) begin
      op.neg       = op_q[31];
      op.exp       = {3'd0, op_q[30:23]};
      op.mant      = {29'd0, 1'b1, op_q[22:0]};
      op.is_nan    = (op_q[30:23] == 8'hff) && (op_q[22:0] != '0);
      op.is_inf    = (op_q[30:23] == 8'hff) && (op_q[22:0] == '0);
      op.is_zero   = (op_q[30:23] == 8'h00);
      op.bias      = f2i_pkg::BiasS;
      op.frac_bits = f2i_pkg::FracBitsS;
    end else begin
      op.neg       = op_q[63];
      op.exp       = op_q[62:52];
      op.mant      = {1'b1, op_q[51:0]};
      op.is_nan    = (op_q[62:52] == 11'h7ff) && (op_q[51:0] != '0);
      op.is_inf    = (op_q[62:52] == 11'h7ff) && (op_q[51:0] == '0);
      op.is_zero   = (op_q[62:52] == 11'h000);
      op.bias      = f2i_pkg::BiasD;
      op.frac_bits = f2i_pkg::FracBitsD;
    end
  end

  function automatic logic [63:0] op_t_shl(logic [52:0] m, logic [11:0] sh);
    logic [63:0] w;
    w = {11'd0, m};
    return w << sh[5:0];
  endfunction

  // magnitude and saturation
  logic [11:0] ebig;
  logic [11:0] rsh;
  logic [64:0] mant_x, sum;
  logic [63:0] mag;
  logic        over;
  always_comb begin
    ebig   = {1'b0, op.exp};
    rsh    = {1'b0, op.bias} + {1'b0, op.frac_bits} - ebig;
    mant_x = {12'd0, op.mant};
    mag    = '0;
    over   = op.is_inf;
    sum    = '0;
    if (op.is_inf || op.is_nan || op.is_zero) begin
      mag = '0;
    end else if (ebig + 12'd1 < {1'b0, op.bias}) begin
      mag = '0;
    end else if (ebig >= {1'b0, op.bias} + 12'd64) begin
      over = 1'b1;
    end else if (ebig >= {1'b0, op.bias} + {1'b0, op.frac_bits}) begin
      mag = op_t_shl(op.mant, ebig - {1'b0, op.bias} - {1'b0, op.frac_bits});
    end else begin
      sum = mant_x + (65'd1 << (rsh[5:0] - 6'd1));
      mag = 64'(sum >> rsh[5:0]);
    end
    if (!over) over = op.neg ? (mag > NegLimit) : (mag > PosLimit);
    if (op.is_nan) begin
      res_d = '0;
      inv_d = 1'b1;
    end else if (over) begin
      res_d = op.neg ? (64'd0 - NegLimit) : PosLimit;
      inv_d = 1'b1;
    end else begin
      res_d = op.neg ? (64'd0 - mag) : mag;
      inv_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, inv_q, res_q};

  // a held result stays put while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> $stable(res_q) && $stable(inv_q))
    else $error("result changed under stall");
  // an item in the input stage reaches the result register unless stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv_out |=> out_vld_q)
    else $error("item lost between stages");
  // invalid results are only zero or a limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && inv_q |-> (res_q == '0) || (res_q == PosLimit)
                           || (res_q == 64'd0 - NegLimit))
    else $error("invalid with a non-limit value");

endmodule

### verif/f2i_checker.sv
module f2i_checker #(
  parameter int unsigned RESULT_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [71:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [71:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] value;
    logic        invalid;
  } conv_t;

  conv_t conv_q[$];

  // nearest integer, halves away from zero, saturated to RESULT_WIDTH
  function automatic conv_t round_half_away(logic [63:0] bits, logic single);
    conv_t       r;
    logic        neg;
    int          ex;
    int          bias;
    int          fb;
    logic [63:0] frac;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] nlim;
    logic [63:0] plim;
    logic        over;
    logic        nan;
    int          w;
    int          s;
    w = (RESULT_WIDTH > 64) ? 64 : ((RESULT_WIDTH < 2) ? 2 : RESULT_WIDTH);
    nlim = 64'd1 << (w - 1);
    plim = nlim - 64'd1;
    mag = '0;
    over = 1'b0;
    nan = 1'b0;
    if (single) begin
      neg = bits[31]; ex = int'(bits[30:23]); frac = {41'd0, bits[22:0]};
      fb = 23; bias = 127;
    end else begin
      neg = bits[63]; ex = int'(bits[62:52]); frac = {12'd0, bits[51:0]};
      fb = 52; bias = 1023;
    end
    if (ex == (single ? 255 : 2047)) begin
      if (frac != 0) nan = 1'b1;
      else over = 1'b1;
    end else if (ex != 0) begin
      m = frac | (64'd1 << fb);
      if (ex + 1 < bias) mag = '0;
      else if (ex >= bias + 64) over = 1'b1;
      else if (ex >= bias + fb) mag = m << (ex - bias - fb);
      else begin
        s = bias + fb - ex;
        mag = (m + (64'd1 << (s - 1))) >> s;
      end
    end
    if (!over && !nan) over = neg ? (mag > nlim) : (mag > plim);
    if (nan) r = '{value: '0, invalid: 1'b1};
    else if (over) r = '{value: neg ? -nlim : plim, invalid: 1'b1};
    else r = '{value: neg ? -mag : mag, invalid: 1'b0};
    return r;
  endfunction

  assign pending_o = conv_q.size();

  always @(posedge clk_i) begin
    conv_t got;
    conv_t want;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        conv_q.push_back(round_half_away(s_axis_tdata_i[63:0], s_axis_tdata_i[64]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{value: m_axis_tdata_i[63:0], invalid: m_axis_tdata_i[64]};
        if (conv_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected item %h/%b", $time, got.value, got.invalid);
        end else begin
          want = conv_q.pop_front();
          if (got.value !== want.value) begin
            errs++;
            $display("%0t: value exp %h act %h", $time, want.value, got.value);
          end
          if (got.invalid !== want.invalid) begin
            errs++;
            $display("%0t: invalid exp %b act %b", $time, want.invalid, got.invalid);
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // [63:0] operand_bits, [64] is_single
  logic        m_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;   // [63:0] rounded_value, [64] invalid
  int          fails;
  int          pending;
  int          idle_cycles;
  bit          quiet_tail;  // no idling in the last part of the run
  bit          timed_out;

  localparam int WatchdogLimit = 2000;

  float_to_int_round_half_away DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tready_i(m_tready), .m_axis_tvalid_o(m_tvalid), .m_axis_tdata_o(m_tdata)
  );

  f2i_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  // pick a random operand, biased towards exponents near the rounding boundaries
  function automatic logic [64:0] rand_operand();
    logic [63:0] b;
    logic        single;
    int          k;
    b = {$urandom, $urandom};
    single = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 9);
    if (single) begin
      if (k < 7) b[30:23] = 8'($urandom_range(120, 192));
      else if (k == 7) b[30:23] = 8'hff;
      else if (k == 8) b[30:23] = 8'h00;
      if ($urandom_range(0, 3) == 0) b[22:0] = 23'h400000 >> $urandom_range(0, 22);
    end else begin
      if (k < 7) b[62:52] = 11'($urandom_range(1016, 1090));
      else if (k == 7) b[62:52] = 11'h7ff;
      else if (k == 8) b[62:52] = 11'h000;
      if ($urandom_range(0, 3) == 0) b[51:0] = 52'h8000000000000 >> $urandom_range(0, 51);
    end
    if (k == 7 && !single && $urandom_range(0, 1) == 0) b[51:0] = '0;
    if (k == 7 && single && $urandom_range(0, 1) == 0) b[22:0] = '0;
    return {single, b};
  endfunction

  task automatic send(logic [64:0] item);
    s_tdata <= {7'd0, item};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_paced(logic [64:0] item);
    int n;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    send(item);
  endtask

  logic [64:0] directed[$] = '{
    {1'b0, 64'h0000000000000000}, {1'b0, 64'h8000000000000000},  // zeros
    {1'b0, 64'h000fffffffffffff},                                 // subnormal
    {1'b0, 64'h3fdfffffffffffff}, {1'b0, 64'h3fe0000000000000},   // below and at one half
    {1'b0, 64'hbfe0000000000000}, {1'b0, 64'h4004000000000000},   // -0.5, 2.5
    {1'b0, 64'h43dfffffffffffff}, {1'b0, 64'h43e0000000000000},   // near and at 2^63
    {1'b0, 64'hc3e0000000000000}, {1'b0, 64'hc3e0000000000001},   // -2^63 and beyond
    {1'b0, 64'h7ff0000000000000}, {1'b0, 64'hfff0000000000000},   // infinities
    {1'b0, 64'h7ff8000000000001}, {1'b0, 64'hffffffffffffffff},   // nans
    {1'b0, 64'h4330000000000000}, {1'b0, 64'h432fffffffffffff},   // ulp at one
    {1'b1, 64'hffffffff00000000}, {1'b1, 64'h000000003f000000},   // single zero, 0.5
    {1'b1, 64'h00000000bfc00000}, {1'b1, 64'h000000005f000000},   // -1.5, 2^63
    {1'b1, 64'h00000000df000000}, {1'b1, 64'h000000007f800000},   // -2^63, +inf
    {1'b1, 64'hffffffffff800001}, {1'b1, 64'h00000000007fffff}    // nan, subnormal
  };

  initial begin
    int wait_cycles;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    quiet_tail = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_paced(directed[i]);
    for (int i = 0; i < 950; i++) begin
      if (i == 800) quiet_tail = 1'b1;
      send_paced(rand_operand());
    end
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < WatchdogLimit) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(negedge clk_i);
    if (fails == 0 && pending == 0 && !DUT_result_stray()) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  function automatic bit DUT_result_stray();
    return m_tvalid;
  endfunction
endmodule

### files.f
rtl/f2i_pkg.sv
rtl/float_to_int_round_half_away.sv
verif/f2i_checker.sv
verif/tb_top.sv
